// ===== sv/orb_pkg.sv =====
`default_nettype none

package orb_pkg;

	// Fixed field widths of one request and one result.
	localparam int WORD_W   = 32;
	localparam int OFFSET_W = 8;
	localparam int COUNT_W  = 8;
	localparam int ACTION_W = 2;

	// Operation codes carried by the action field.
	typedef enum logic [ACTION_W-1:0] {
		ACT_ENQUEUE = 2'd0,
		ACT_DEQUEUE = 2'd1,
		ACT_PEEK    = 2'd2,
		ACT_SKIP    = 2'd3
	} action_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // Capture the request fields.
		logic exec;     // Access the memory and move the pointers.
		logic respond;  // Register the result and raise the strobe.
	} orb_cmd_t;

endpackage

`default_nettype wire

// ===== sv/orb_ctrl.sv =====
`default_nettype none

module orb_ctrl
	import orb_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	output orb_cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   exec_q;
	logic   resp_q;

	// Sequence one request through execute and respond.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			exec_q  <= 1'b0;
			resp_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
						busy_q  <= 1'b1;
						exec_q  <= 1'b1;
					end
				end
				ST_EXEC: begin
					state_q <= ST_RESP;
					exec_q  <= 1'b0;
					resp_q  <= 1'b1;
				end
				ST_RESP: begin
					state_q <= ST_IDLE;
					resp_q  <= 1'b0;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					exec_q  <= 1'b0;
					resp_q  <= 1'b0;
				end
			endcase
		end
	end

	// A request is taken whenever the block is not busy.
	assign busy        = busy_q;
	assign cmd.load    = start & ~busy_q;
	assign cmd.exec    = exec_q;
	assign cmd.respond = resp_q;

endmodule

`default_nettype wire

// ===== sv/orb_datapath.sv =====
`default_nettype none

module orb_datapath
	import orb_pkg::*;
#(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire orb_cmd_t            cmd,
	input  wire logic [ACTION_W-1:0] action,
	input  wire logic [WORD_W-1:0]   write_data,
	input  wire logic [OFFSET_W-1:0] peek_offset,
	input  wire logic [COUNT_W-1:0]  skip_count,
	output logic                     done,
	output logic                     ok,
	output logic [WORD_W-1:0]        read_data,
	output logic [COUNT_W-1:0]       item_count,
	output logic                     is_full,
	output logic                     is_empty
);

	localparam int AW = $clog2(DEPTH);
	// Only the bits that survive both the field width and the word width are stored.
	localparam int SW = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;
	// Width that holds both an 8-bit operand and a count.
	localparam int CW = (AW > OFFSET_W) ? AW : OFFSET_W;

	logic [SW-1:0] mem [DEPTH];

	action_t             action_q;
	logic [SW-1:0]       wdata_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [COUNT_W-1:0]  skip_q;

	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;

	logic [SW-1:0] rdata_s1;
	logic          ok_s1;
	logic          rd_sel_s1;

	logic          done_q;
	logic          ok_q;
	logic [WORD_W-1:0]  rdata_q;
	logic [COUNT_W-1:0] count_q;
	logic          full_q;
	logic          empty_q;

	logic [AW-1:0] count;
	logic          now_empty;
	logic          now_full;
	logic [CW-1:0] count_ext;
	logic [CW-1:0] offset_ext;
	logic [CW-1:0] skip_ext;
	logic [CW-1:0] skip_eff;
	logic [AW-1:0] head_nxt;
	logic [AW-1:0] tail_nxt;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic          op_ok;
	logic          rd_sel;
	logic [AW-1:0] count_after;

	// Capture the request fields when it is accepted.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action_t'(action);
			wdata_q  <= write_data[SW-1:0];
			offset_q <= peek_offset;
			skip_q   <= skip_count;
		end
	end

	// Occupancy before the operation.
	assign count      = head_q - tail_q;
	assign now_empty  = (count == '0);
	assign now_full   = &count;
	assign count_ext  = CW'(count);
	assign offset_ext = CW'(offset_q);
	assign skip_ext   = CW'(skip_q);
	assign skip_eff   = (skip_ext > count_ext) ? count_ext : skip_ext;

	// Decode the operation into pointer moves and memory accesses.
	always_comb begin
		head_nxt = head_q;
		tail_nxt = tail_q;
		rd_addr  = tail_q;
		wr_en    = 1'b0;
		op_ok    = 1'b0;
		rd_sel   = 1'b0;
		unique case (action_q)
			ACT_ENQUEUE: begin
				wr_en    = 1'b1;
				op_ok    = 1'b1;
				head_nxt = head_q + AW'(1);
				if (now_full) begin
					tail_nxt = tail_q + AW'(1);
				end
			end
			ACT_DEQUEUE: begin
				op_ok  = ~now_empty;
				rd_sel = ~now_empty;
				if (!now_empty) begin
					tail_nxt = tail_q + AW'(1);
				end
			end
			ACT_PEEK: begin
				op_ok   = (offset_ext < count_ext);
				rd_sel  = (offset_ext < count_ext);
				rd_addr = tail_q + AW'(offset_q);
			end
			ACT_SKIP: begin
				op_ok    = ~now_empty;
				tail_nxt = tail_q + AW'(skip_eff);
			end
			default: begin
				op_ok = 1'b0;
			end
		endcase
	end

	// Slot memory with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (wr_en) begin
				mem[head_q] <= wdata_q;
			end
			rdata_s1 <= mem[rd_addr];
		end
	end

	// Status of the executed operation, held for the response step.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			ok_s1     <= op_ok;
			rd_sel_s1 <= rd_sel;
		end
	end

	// Head and tail pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (cmd.exec) begin
			head_q <= head_nxt;
			tail_q <= tail_nxt;
		end
	end

	// Occupancy after the operation.
	assign count_after = head_q - tail_q;

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.respond;
		end
	end

	// Result fields.
	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			ok_q    <= ok_s1;
			rdata_q <= rd_sel_s1 ? WORD_W'(rdata_s1) : '0;
			count_q <= COUNT_W'(count_after);
			full_q  <= &count_after;
			empty_q <= (count_after == '0);
		end
	end

	assign done       = done_q;
	assign ok         = ok_q;
	assign read_data  = rdata_q;
	assign item_count = count_q;
	assign is_full    = full_q;
	assign is_empty   = empty_q;

endmodule

`default_nettype wire

// ===== sv/overwriting_ring_buffer.sv =====
// A request accepted at a clock edge has its fields captured, then its memory access and
// pointer move, then its result registered; the result is on the ports with done high.
// A new request is not taken until the previous one has been answered, set by the slot
// memory's registered read followed by the result register; busy drops in the cycle that shows the result.
// Reset clears the pointers, so the buffer starts empty; the slots are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module overwriting_ring_buffer
	import orb_pkg::*;
#(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [ACTION_W-1:0] action,
	input  wire logic [WORD_W-1:0]   write_data,
	input  wire logic [OFFSET_W-1:0] peek_offset,
	input  wire logic [COUNT_W-1:0]  skip_count,
	output logic                     done,
	output logic                     ok,
	output logic [WORD_W-1:0]        read_data,
	output logic [COUNT_W-1:0]       item_count,
	output logic                     is_full,
	output logic                     is_empty
);

	orb_cmd_t cmd;

	// Sequencer for one request at a time.
	orb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Slot memory, pointers and result registers.
	orb_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.action      (action),
		.write_data  (write_data),
		.peek_offset (peek_offset),
		.skip_count  (skip_count),
		.done        (done),
		.ok          (ok),
		.read_data   (read_data),
		.item_count  (item_count),
		.is_full     (is_full),
		.is_empty    (is_empty)
	);

endmodule

`default_nettype wire

// ===== sv/orb_checker.sv =====
`default_nettype none

module orb_checker
	import orb_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire logic                done,
	input wire logic                ok,
	input wire logic [WORD_W-1:0]   read_data,
	input wire logic                is_full,
	input wire logic                is_empty
);

	// An accepted request makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after an accepted request");

	// Every accepted request is followed by its result strobe.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##2 done)
		else $error("result strobe missing after an accepted request");

	// A failed operation returns no data.
	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ok |-> read_data == '0)
		else $error("failed operation returned data");

	// The buffer is never full and empty at once.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(is_full && is_empty))
		else $error("full and empty flags both set");

endmodule

bind overwriting_ring_buffer orb_checker u_orb_checker (.*);

`default_nettype wire
